/* hw/rtl/call_return_tracer_top_macros.svh */
// Assertion helpers for the call/return tracer.
// Both expect i_clk and i_rst_n in the scope of the use.
`ifndef CALL_RETURN_TRACER_TOP_MACROS_SVH
`define CALL_RETURN_TRACER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define CRT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tracer check failed");

// Next-cycle implication, disabled while in reset
`define CRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tracer check failed");

`endif

/* hw/rtl/crt_pkg.sv */
package crt_pkg;

    // Input word kinds (tuser of the slave side)
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    // Event kinds (tuser of the master side)
    localparam logic [1:0] EV_CALL    = 2'd0;
    localparam logic [1:0] EV_RET     = 2'd1;
    localparam logic [1:0] EV_RET_UNK = 2'd2;

    // RV32 decode constants
    localparam logic [6:0] OPC_JAL  = 7'h6f;
    localparam logic [6:0] OPC_JALR = 7'h67;
    localparam logic [2:0] F3_JALR  = 3'd0;
    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd1;

    // Stream widths and result field positions
    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_IDX_LSB = 64;
    localparam int OUT_FULL_BIT = 79;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP,
        ST_SEARCH,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic        clr;
        logic        load;
        logic        search;
        logic [31:0] addr;
        logic [31:0] ld_start;
        logic [31:0] ld_size;
    } t_tbl_req;

    typedef struct packed {
        logic done;
        logic hit;
    } t_tbl_rsp;

    typedef struct packed {
        logic        push;
        logic        pop;
        logic [31:0] data;
    } t_stk_req;

endpackage

/* hw/rtl/crt_range_table.sv */
module crt_range_table import crt_pkg::*; #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_tbl_req                 i_req,
    output t_tbl_rsp                 o_rsp,
    output logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] o_idx
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    // Range storage: {size, start} per entry
    logic [63:0]    mem [TABLE_ENTRIES];

    logic [CW-1:0]  r_count;
    logic           r_busy;
    logic [CW-1:0]  r_issue;
    logic           r_cmp_vld;
    logic [IW-1:0]  r_cmp_idx;
    logic [31:0]    r_addr;
    logic [63:0]    r_ent;
    logic           r_done;
    logic           r_hit;
    logic [IW-1:0]  r_idx;

    logic           w_room;
    logic           w_rd_en;
    logic [31:0]    w_start;
    logic [31:0]    w_size;
    logic [31:0]    w_diff;
    logic           w_hit;
    logic           w_last;

    assign w_room  = r_count < CW'(TABLE_ENTRIES);
    assign w_rd_en = r_busy && (r_issue < r_count);

    // Shared range comparator, one entry per cycle
    assign w_start = r_ent[31:0];
    assign w_size  = r_ent[63:32];
    assign w_diff  = r_addr - w_start;
    assign w_hit   = (w_size == 32'd0) ? (r_addr == w_start)
                                       : ((r_addr >= w_start) && (w_diff < w_size));
    assign w_last  = (CW'(r_cmp_idx) + CW'(1)) == r_count;

    // Write loads, read one entry a cycle during a search
    always_ff @(posedge i_clk) begin
        if (i_req.load && w_room) begin
            mem[r_count[IW-1:0]] <= {i_req.ld_size, i_req.ld_start};
        end
        if (w_rd_en) begin
            r_ent <= mem[r_issue[IW-1:0]];
        end
        if (i_req.search) begin
            r_addr <= i_req.addr;
        end
    end

    // Fill count and search sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_busy    <= 1'b0;
            r_issue   <= '0;
            r_cmp_vld <= 1'b0;
            r_cmp_idx <= '0;
            r_done    <= 1'b0;
            r_hit     <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.clr) begin
                r_count <= '0;
            end else if (i_req.load && w_room) begin
                r_count <= r_count + CW'(1);
            end
            if (i_req.search) begin
                r_cmp_vld <= 1'b0;
                r_issue   <= '0;
                if (r_count == '0) begin
                    r_done <= 1'b1;
                    r_hit  <= 1'b0;
                    r_idx  <= '0;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cmp_vld <= w_rd_en;
                if (w_rd_en) begin
                    r_issue   <= r_issue + CW'(1);
                    r_cmp_idx <= r_issue[IW-1:0];
                end
                // stop at the first hit or after the last entry
                if (r_cmp_vld && (w_hit || w_last)) begin
                    r_busy    <= 1'b0;
                    r_cmp_vld <= 1'b0;
                    r_done    <= 1'b1;
                    r_hit     <= w_hit;
                    r_idx     <= w_hit ? r_cmp_idx : '0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.hit  = r_hit;
    assign o_idx      = r_idx;

endmodule

/* hw/rtl/crt_ret_stack.sv */
module crt_ret_stack import crt_pkg::*; #(
    parameter int STACK_ENTRIES = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_stk_req                           i_req,
    output logic [$clog2(STACK_ENTRIES+1)-1:0] o_level,
    output logic                               o_full,
    output logic                               o_empty,
    output logic [31:0]                        o_rdata
);

    localparam int LW = $clog2(STACK_ENTRIES + 1);
    localparam int AW = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;

    logic [31:0]   mem [STACK_ENTRIES];
    logic [LW-1:0] r_level;
    logic [31:0]   r_rdata;
    logic [LW-1:0] w_level_dec;

    assign o_full      = r_level == LW'(STACK_ENTRIES);
    assign o_empty     = r_level == '0;
    assign w_level_dec = r_level - LW'(1);

    // Push writes the top slot, pop reads the slot below the level
    always_ff @(posedge i_clk) begin
        if (i_req.push && !o_full) begin
            mem[r_level[AW-1:0]] <= i_req.data;
        end
        if (i_req.pop && !o_empty) begin
            r_rdata <= mem[w_level_dec[AW-1:0]];
        end
    end

    // Track the stack level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_req.push && !o_full) begin
            r_level <= r_level + LW'(1);
        end else if (i_req.pop && !o_empty) begin
            r_level <= w_level_dec;
        end
    end

    assign o_level = r_level;
    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/call_return_tracer_top.sv */
// Call/return tracer. Each word on the slave stream is a table clear, a table
// load or a retired RV32 instruction to check (kind in tuser). Clear, load and
// instructions that are not calls or returns pass from ST_IDLE through
// ST_DECODE and back. A call (JAL or JALR with rd=ra) or a return
// (jalr x0,0(ra)) on a non-empty stack searches the function table one entry
// per cycle through the single table read port and its range comparator,
// stopping at the first hit; a missed call gives no event. A return first
// pops its target through the stack memory's registered read port, and one
// on an empty stack is finished with no search and no event. The
// slave side stays not ready until the word is finished. At most one event per
// word leaves on the master stream through an output register; the next word
// may be accepted while that event waits, and a word that has its own event
// stalls while the output register still holds an earlier one.
// Table and stack memories need no clearing pass after reset.
module call_return_tracer_top import crt_pkg::*; #(
    parameter int TABLE_ENTRIES = 256,
    parameter int STACK_ENTRIES = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // entry_start, entry_size, instruction, instr_pc, rs1_value (32 bits each)
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // event_pc (32), target_addr (32), function_index (8), nesting_depth (7),
    // stack_full (1)
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // event_kind
    output logic [1:0]             m_axis_tuser
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LW = $clog2(STACK_ENTRIES + 1);

    t_state       r_state, n_state;
    t_tbl_req     w_tbl_req;
    t_tbl_rsp     w_tbl_rsp;
    t_stk_req     w_stk_req;
    logic [IW-1:0] w_idx;
    logic [LW-1:0] w_level;
    logic          w_full;
    logic          w_empty;
    logic [31:0]   w_stk_rdata;

    // Captured input word
    logic [1:0]   r_op;
    logic [31:0]  r_ld_start;
    logic [31:0]  r_ld_size;
    logic [31:0]  r_instr;
    logic [31:0]  r_pc;
    logic [31:0]  r_rs1v;

    logic [31:0]  r_target;
    logic         r_is_ret;

    // Pending result and output register
    logic [1:0]   r_res_kind;
    logic [31:0]  r_res_target;
    logic [7:0]   r_res_idx;
    logic [6:0]   r_res_depth;
    logic         r_res_full;
    logic         r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;
    logic [1:0]   r_m_kind;

    logic         w_accept;
    logic         w_load_out;
    logic         w_done_emit;

    // Decode
    logic [6:0]   w_opc;
    logic [4:0]   w_rd;
    logic [4:0]   w_rs1;
    logic [2:0]   w_f3;
    logic         w_is_jal;
    logic         w_is_jalr;
    logic         w_is_ret;
    logic         w_is_call;
    logic [31:0]  w_jimm;
    logic [31:0]  w_iimm;
    logic [31:0]  w_sum;
    logic [31:0]  w_target;
    logic [IW+7:0] w_idx_ext;
    logic [LW+6:0] w_lvl_ext;

    assign w_opc     = r_instr[6:0];
    assign w_rd      = r_instr[11:7];
    assign w_f3      = r_instr[14:12];
    assign w_rs1     = r_instr[19:15];
    assign w_is_jal  = w_opc == OPC_JAL;
    assign w_is_jalr = (w_opc == OPC_JALR) && (w_f3 == F3_JALR);
    assign w_is_ret  = w_is_jalr && (w_rd == REG_ZERO) && (w_rs1 == REG_RA)
                     && (r_instr[31:20] == 12'd0);
    assign w_is_call = (w_rd == REG_RA) && (w_is_jal || (w_is_jalr && !w_is_ret));
    assign w_jimm    = {{11{r_instr[31]}}, r_instr[31], r_instr[19:12], r_instr[20],
                        r_instr[30:21], 1'b0};
    assign w_iimm    = {{20{r_instr[31]}}, r_instr[31:20]};

    // One adder for both jump kinds
    assign w_sum     = (w_is_jal ? r_pc : r_rs1v) + (w_is_jal ? w_jimm : w_iimm);
    assign w_target  = w_is_jal ? w_sum : {w_sum[31:1], 1'b0};

    assign w_idx_ext = {8'd0, w_idx};
    assign w_lvl_ext = {7'd0, w_level};

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_load_out  = (r_state == ST_EMIT) && (!r_m_valid || m_axis_tready);
    assign w_done_emit = w_tbl_rsp.done && (w_tbl_rsp.hit || r_is_ret);

    crt_range_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_tbl_req),
        .o_rsp   (w_tbl_rsp),
        .o_idx   (w_idx)
    );

    crt_ret_stack #(
        .STACK_ENTRIES (STACK_ENTRIES)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_stk_req),
        .o_level (w_level),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_rdata (w_stk_rdata)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state and unit requests
    always_comb begin
        n_state            = r_state;
        s_axis_tready      = 1'b0;
        w_tbl_req          = '0;
        w_tbl_req.ld_start = r_ld_start;
        w_tbl_req.ld_size  = r_ld_size;
        w_stk_req          = '0;
        w_stk_req.data     = r_target;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_IDLE;
                case (r_op)
                    OP_CLEAR: w_tbl_req.clr = 1'b1;
                    OP_LOAD:  w_tbl_req.load = 1'b1;
                    OP_CHECK: begin
                        if (w_is_call) begin
                            w_tbl_req.search = 1'b1;
                            w_tbl_req.addr   = w_target;
                            n_state          = ST_SEARCH;
                        end else if (w_is_ret && !w_empty) begin
                            w_stk_req.pop = 1'b1;
                            n_state       = ST_POP;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_POP: begin
                w_tbl_req.search = 1'b1;
                w_tbl_req.addr   = w_stk_rdata;
                n_state          = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (w_tbl_rsp.done) begin
                    n_state = w_done_emit ? ST_EMIT : ST_IDLE;
                    // push a found call target while there is room
                    if (!r_is_ret && w_tbl_rsp.hit && !w_full) begin
                        w_stk_req.push = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Capture the word, the target and the pending event
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= s_axis_tuser;
            r_ld_start <= s_axis_tdata[31:0];
            r_ld_size  <= s_axis_tdata[63:32];
            r_instr    <= s_axis_tdata[95:64];
            r_pc       <= s_axis_tdata[127:96];
            r_rs1v     <= s_axis_tdata[159:128];
        end
        if (r_state == ST_DECODE) begin
            r_target <= w_target;
            r_is_ret <= w_is_ret;
        end else if (r_state == ST_POP) begin
            r_target <= w_stk_rdata;
        end
        if ((r_state == ST_SEARCH) && w_tbl_rsp.done) begin
            r_res_target <= r_target;
            r_res_idx    <= w_idx_ext[7:0];
            r_res_depth  <= w_lvl_ext[6:0];
            if (r_is_ret) begin
                r_res_kind <= w_tbl_rsp.hit ? EV_RET : EV_RET_UNK;
                r_res_full <= 1'b0;
            end else begin
                r_res_kind <= EV_CALL;
                r_res_full <= w_full;
            end
        end
        if (w_load_out) begin
            r_m_data <= {r_res_full, r_res_depth, r_res_idx, r_res_target, r_pc};
            r_m_kind <= r_res_kind;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_kind;

endmodule

/* hw/rtl/crt_checker.sv */
`include "call_return_tracer_top_macros.svh"

module crt_checker import crt_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]             m_axis_tuser
);

    logic                     w_out_stall;
    logic                     w_in_accept;
    logic                     w_ret_event;
    logic                     w_unk_event;
    logic [OUT_TDATA_W+1:0]   w_out_word;
    logic [7:0]               w_out_idx;

    assign w_out_stall = m_axis_tvalid && !m_axis_tready;
    assign w_in_accept = s_axis_tvalid && s_axis_tready;
    assign w_ret_event = m_axis_tvalid && (m_axis_tuser != EV_CALL);
    assign w_unk_event = m_axis_tvalid && (m_axis_tuser == EV_RET_UNK);
    assign w_out_word  = {m_axis_tuser, m_axis_tdata};
    assign w_out_idx   = m_axis_tdata[OUT_IDX_LSB+7:OUT_IDX_LSB];

    // Stalled event word holds
    `CRT_ASSERT_NEXT(a_out_hold, w_out_stall, m_axis_tvalid && $stable(w_out_word))

    // Ready is low in the cycle after every accepted word
    `CRT_ASSERT_NEXT(a_busy_after_accept, w_in_accept, !s_axis_tready)

    // Returns never report a full stack
    `CRT_ASSERT_NOW(a_ret_not_full, w_ret_event, !m_axis_tdata[OUT_FULL_BIT])

    // Unknown return targets carry function index zero
    `CRT_ASSERT_NOW(a_unk_idx_zero, w_unk_event, w_out_idx == 8'd0)

endmodule

bind call_return_tracer_top crt_checker u_crt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
